[src/fourier_layout_address_map_unit_macros.svh]
// Assertion macros used by the checker file of the Fourier layout address map.
`ifndef FOURIER_LAYOUT_ADDRESS_MAP_UNIT_MACROS_SVH
`define FOURIER_LAYOUT_ADDRESS_MAP_UNIT_MACROS_SVH

// Clocked property that is not checked while reset is high.
`define FLAM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is checked on every edge, reset included.
`define FLAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/flam_pkg.sv]
// Shared types, codes and widths of the Fourier layout address map.
package flam_pkg;

  localparam int COORD_W    = 10;
  localparam int IMAGE_W    = 8;
  localparam int INDEX_W    = 38;
  localparam int SIZE_W     = 11;
  localparam int LAYOUT_W   = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int PROD_W     = 18;
  localparam int MID_W      = 28;

  // Largest transform size on any axis.
  localparam logic [SIZE_W-1:0] MAX_DIM = 11'd1024;

  // Layout codes.
  localparam logic [LAYOUT_W-1:0] LAY_NONE     = 3'd0;
  localparam logic [LAYOUT_W-1:0] LAY_STANDARD = 3'd1;
  localparam logic [LAYOUT_W-1:0] LAY_CENTERED = 3'd2;
  localparam logic [LAYOUT_W-1:0] LAY_HERM     = 3'd3;
  localparam logic [LAYOUT_W-1:0] LAY_CENTHERM = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_X     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Y     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Z     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OLD_LAYOUT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NEW_LAYOUT = 3'd4;

  // Input beat: one destination coordinate.
  typedef struct packed {
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [IMAGE_W-1:0] image_index;
  } coord_t;

  // Output beat: both linear indices and the conjugate flag.
  typedef struct packed {
    logic [INDEX_W-1:0] dest_index;
    logic [INDEX_W-1:0] source_index;
    logic               conjugate;
  } addr_t;

  // Geometry derived from the configuration registers.
  typedef struct packed {
    logic [SIZE_W-1:0]         nx;
    logic [SIZE_W-1:0]         ny;
    logic [SIZE_W-1:0]         nz;
    logic [COORD_W-1:0]        half;
    logic [SIZE_W-1:0]         old_row;
    logic [SIZE_W-1:0]         new_row;
    logic signed [SIZE_W-1:0]  xd;
    logic signed [SIZE_W-1:0]  yd;
    logic signed [SIZE_W-1:0]  zd;
    logic [SIZE_W-1:0]         y2o;
    logic [SIZE_W-1:0]         z2o;
    logic                      expand;
  } geo_t;

  // Coordinate with partial remainders on each axis.
  typedef struct packed {
    coord_t             item;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] rz;
  } rem_t;

  // Coordinate with source coordinates and conjugate flag.
  typedef struct packed {
    coord_t             item;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] sz;
    logic               conj;
  } wrap_t;

endpackage

[src/fourier_layout_address_map_unit.sv]
// Throughput: one coordinate per cycle while addr_ready does not hold the pipeline;
// each coordinate passes 12 register stages (8 coordinate, 4 index).
// The modulo reduction takes two quotient bits per stage over five stages.
// Each stage stalls on its own, so bubbles close up while the output waits.
// Reset clears all valid bits and sets sizes to 1 and both layouts to standard.
module fourier_layout_address_map_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              coord_valid,
  output logic                              coord_ready,
  input  flam_pkg::coord_t                  coord,
  output logic                              addr_valid,
  input  logic                              addr_ready,
  output flam_pkg::addr_t                   addr,
  input  logic                              cfg_write,
  input  logic [flam_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [flam_pkg::CFG_DATA_W-1:0]   cfg_data
);

  flam_pkg::geo_t  geo;
  flam_pkg::wrap_t wrap_data;
  logic            wrap_valid;
  logic            wrap_ready;

  // Configuration registers and derived geometry.
  flam_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geo       (geo)
  );

  // Coordinate mapping.
  flam_wrap u_wrap (
    .clk       (clk),
    .rst       (rst),
    .geo       (geo),
    .in_valid  (coord_valid),
    .in_ready  (coord_ready),
    .in_data   (coord),
    .out_valid (wrap_valid),
    .out_ready (wrap_ready),
    .out_data  (wrap_data)
  );

  // Linear index arithmetic.
  flam_index u_index (
    .clk       (clk),
    .rst       (rst),
    .geo       (geo),
    .in_valid  (wrap_valid),
    .in_ready  (wrap_ready),
    .in_data   (wrap_data),
    .out_valid (addr_valid),
    .out_ready (addr_ready),
    .out_data  (addr)
  );

endmodule

[src/flam_cfg.sv]
// Configuration registers and the geometry derived from them.
module flam_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [flam_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [flam_pkg::CFG_DATA_W-1:0]     cfg_data,
  output flam_pkg::geo_t                      geo
);

  logic [flam_pkg::SIZE_W-1:0]   size_x;
  logic [flam_pkg::SIZE_W-1:0]   size_y;
  logic [flam_pkg::SIZE_W-1:0]   size_z;
  logic [flam_pkg::LAYOUT_W-1:0] old_layout;
  logic [flam_pkg::LAYOUT_W-1:0] new_layout;

  flam_pkg::geo_t                geo_next;
  logic [flam_pkg::SIZE_W-1:0]   nx, ny, nz;
  logic [flam_pkg::LAYOUT_W-1:0] ol, nl;
  logic                          same;
  logic [flam_pkg::COORD_W-1:0]  xo1, xo2, yo1, yo2, zo1, zo2;

  function automatic logic [flam_pkg::SIZE_W-1:0] clamp(input logic [flam_pkg::SIZE_W-1:0] s);
    if (s == '0) begin
      return flam_pkg::SIZE_W'(1);
    end else if (s > flam_pkg::MAX_DIM) begin
      return flam_pkg::MAX_DIM;
    end
    return s;
  endfunction

  function automatic logic [flam_pkg::LAYOUT_W-1:0] norm(input logic [flam_pkg::LAYOUT_W-1:0] l);
    if (l == flam_pkg::LAY_NONE || l > flam_pkg::LAY_CENTHERM) begin
      return flam_pkg::LAY_STANDARD;
    end
    return l;
  endfunction

  function automatic logic is_herm(input logic [flam_pkg::LAYOUT_W-1:0] l);
    return (l == flam_pkg::LAY_HERM) || (l == flam_pkg::LAY_CENTHERM);
  endfunction

  // The x axis of the centered hermitian layout keeps its origin at zero.
  function automatic logic [flam_pkg::COORD_W-1:0] origin(
    input logic [flam_pkg::LAYOUT_W-1:0] l,
    input logic [flam_pkg::SIZE_W-1:0]   size,
    input logic                          x_axis
  );
    if (l == flam_pkg::LAY_CENTERED || (l == flam_pkg::LAY_CENTHERM && !x_axis)) begin
      return flam_pkg::COORD_W'(size >> 1);
    end
    return '0;
  endfunction

  function automatic logic signed [flam_pkg::SIZE_W-1:0] odiff(
    input logic [flam_pkg::COORD_W-1:0] o1,
    input logic [flam_pkg::COORD_W-1:0] o2
  );
    return $signed({1'b0, o1}) - $signed({1'b0, o2});
  endfunction

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= flam_pkg::SIZE_W'(1);
      size_y     <= flam_pkg::SIZE_W'(1);
      size_z     <= flam_pkg::SIZE_W'(1);
      old_layout <= flam_pkg::LAY_STANDARD;
      new_layout <= flam_pkg::LAY_STANDARD;
    end else if (cfg_write) begin
      case (cfg_index)
        flam_pkg::REG_SIZE_X:     size_x     <= cfg_data;
        flam_pkg::REG_SIZE_Y:     size_y     <= cfg_data;
        flam_pkg::REG_SIZE_Z:     size_z     <= cfg_data;
        flam_pkg::REG_OLD_LAYOUT: old_layout <= cfg_data[flam_pkg::LAYOUT_W-1:0];
        flam_pkg::REG_NEW_LAYOUT: new_layout <= cfg_data[flam_pkg::LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes, origins, row widths and mirror constants.
  always_comb begin
    nx   = clamp(size_x);
    ny   = clamp(size_y);
    nz   = clamp(size_z);
    ol   = norm(old_layout);
    nl   = norm(new_layout);
    same = (ol == nl);
    xo1  = same ? '0 : origin(ol, nx, 1'b1);
    xo2  = same ? '0 : origin(nl, nx, 1'b1);
    yo1  = same ? '0 : origin(ol, ny, 1'b0);
    yo2  = same ? '0 : origin(nl, ny, 1'b0);
    zo1  = same ? '0 : origin(ol, nz, 1'b0);
    zo2  = same ? '0 : origin(nl, nz, 1'b0);

    geo_next.nx      = nx;
    geo_next.ny      = ny;
    geo_next.nz      = nz;
    geo_next.half    = flam_pkg::COORD_W'((nx >> 1) + flam_pkg::SIZE_W'(1));
    geo_next.old_row = is_herm(ol) ? {1'b0, geo_next.half} : nx;
    geo_next.new_row = is_herm(nl) ? {1'b0, geo_next.half} : nx;
    geo_next.xd      = odiff(xo1, xo2);
    geo_next.yd      = odiff(yo1, yo2);
    geo_next.zd      = odiff(zo1, zo2);
    geo_next.y2o     = {yo1, 1'b0};
    geo_next.z2o     = {zo1, 1'b0};
    geo_next.expand  = is_herm(ol) && !is_herm(nl) && !same;
  end

  // Registered geometry; a write reaches it through the configuration register and then this one.
  always_ff @(posedge clk) begin
    geo <= geo_next;
  end

endmodule

[src/flam_wrap.sv]
// Coordinate pipeline: modulo reduction, origin shift with wraparound and Friedel mirror.
module flam_wrap (
  input  logic            clk,
  input  logic            rst,
  input  flam_pkg::geo_t  geo,
  input  logic            in_valid,
  output logic            in_ready,
  input  flam_pkg::coord_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output flam_pkg::wrap_t out_data
);

  localparam int CW         = flam_pkg::COORD_W;
  localparam int SW         = flam_pkg::SIZE_W;
  localparam int REM_STAGES = CW / 2;
  localparam int NS         = REM_STAGES + 3;
  localparam int SH         = REM_STAGES + 1;

  logic [NS-1:0]     v;
  logic [NS-1:0]     v_in;
  logic [NS:0]       adv;

  flam_pkg::coord_t  c0;
  flam_pkg::rem_t    rem_src [REM_STAGES];
  flam_pkg::rem_t    rem_d   [REM_STAGES];
  flam_pkg::rem_t    rem_q   [REM_STAGES];
  flam_pkg::wrap_t   sh_d, sh_q;
  flam_pkg::wrap_t   mi_d;

  // One restoring step of r mod d at bit position k.
  function automatic logic [CW-1:0] rem_step(
    input logic [CW-1:0] r,
    input logic [SW-1:0] d,
    input int            k
  );
    logic [CW+SW-1:0] dk;
    logic [CW+SW-1:0] rw;
    dk = (CW+SW)'(d) << k;
    rw = (CW+SW)'(r);
    if (rw >= dk) begin
      return CW'(rw - dk);
    end
    return r;
  endfunction

  // Two steps on all three axes.
  function automatic flam_pkg::rem_t rem_pair(
    input flam_pkg::rem_t a,
    input logic [SW-1:0]  nx,
    input logic [SW-1:0]  ny,
    input logic [SW-1:0]  nz,
    input int             k
  );
    flam_pkg::rem_t b;
    b    = a;
    b.rx = rem_step(rem_step(a.rx, nx, k), nx, k - 1);
    b.ry = rem_step(rem_step(a.ry, ny, k), ny, k - 1);
    b.rz = rem_step(rem_step(a.rz, nz, k), nz, k - 1);
    return b;
  endfunction

  // Add the origin difference and fold back into [0, size).
  function automatic logic [CW-1:0] wrap_axis(
    input logic [CW-1:0]        r,
    input logic signed [SW-1:0] d,
    input logic [SW-1:0]        size
  );
    logic signed [CW+2:0] t;
    logic signed [CW+2:0] s;
    s = $signed({2'b00, size});
    t = $signed({3'b000, r}) + (CW+3)'(d);
    if (t < 0) begin
      t = t + s;
    end else if (t >= s) begin
      t = t - s;
    end
    return t[CW-1:0];
  endfunction

  // Friedel mirror on y or z; even and odd sizes follow different rules.
  function automatic logic [CW-1:0] mirror(
    input logic [CW-1:0] i,
    input logic [SW-1:0] o2,
    input logic [SW-1:0] size
  );
    logic signed [CW+2:0] f;
    if (!size[0]) begin
      f = (i != '0) ? ($signed({2'b00, size}) - $signed({3'b000, i})) : '0;
    end else begin
      f = $signed({2'b00, o2}) - $signed({3'b000, i});
      if (f < 0) begin
        f = f + $signed({2'b00, size});
      end
    end
    return f[CW-1:0];
  endfunction

  // A stage may load when it is empty or its content moves on.
  assign adv[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_adv
    assign adv[s] = ~v[s] | adv[s+1];
  end

  assign v_in     = {v[NS-2:0], in_valid};
  assign in_ready = adv[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (adv[s]) begin
          v[s] <= v_in[s];
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      c0 <= in_data;
    end
  end

  // Remainder stages, two quotient bits each.
  for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
    if (g == 0) begin : g_first
      assign rem_src[g] = {c0, c0.coord_x, c0.coord_y, c0.coord_z};
    end else begin : g_next
      assign rem_src[g] = rem_q[g-1];
    end
    assign rem_d[g] = rem_pair(rem_src[g], geo.nx, geo.ny, geo.nz, CW - 1 - 2 * g);
    always_ff @(posedge clk) begin
      if (adv[g+1]) begin
        rem_q[g] <= rem_d[g];
      end
    end
  end

  // Origin shift and conjugate decision.
  always_comb begin
    sh_d.item = rem_q[REM_STAGES-1].item;
    sh_d.sx   = wrap_axis(rem_q[REM_STAGES-1].rx, geo.xd, geo.nx);
    sh_d.sy   = wrap_axis(rem_q[REM_STAGES-1].ry, geo.yd, geo.ny);
    sh_d.sz   = wrap_axis(rem_q[REM_STAGES-1].rz, geo.zd, geo.nz);
    sh_d.conj = geo.expand && (sh_d.sx >= geo.half);
  end

  always_ff @(posedge clk) begin
    if (adv[SH]) begin
      sh_q <= sh_d;
    end
  end

  // Friedel mate for the conjugated half.
  always_comb begin
    mi_d = sh_q;
    if (sh_q.conj) begin
      mi_d.sx = (sh_q.sx != '0) ? CW'(geo.nx - {1'b0, sh_q.sx}) : '0;
      mi_d.sy = mirror(sh_q.sy, geo.y2o, geo.ny);
      mi_d.sz = mirror(sh_q.sz, geo.z2o, geo.nz);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      out_data <= mi_d;
    end
  end

  assign out_valid = v[NS-1];

endmodule

[src/flam_index.sv]
// Index pipeline: linear destination and source indices from the mapped coordinates.
module flam_index (
  input  logic            clk,
  input  logic            rst,
  input  flam_pkg::geo_t  geo,
  input  logic            in_valid,
  output logic            in_ready,
  input  flam_pkg::wrap_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output flam_pkg::addr_t out_data
);

  localparam int NS = 4;
  localparam int CW = flam_pkg::COORD_W;
  localparam int SW = flam_pkg::SIZE_W;
  localparam int PW = flam_pkg::PROD_W;
  localparam int MW = flam_pkg::MID_W;
  localparam int XW = flam_pkg::INDEX_W;

  logic [NS-1:0]    v;
  logic [NS-1:0]    v_in;
  logic [NS:0]      adv;

  flam_pkg::wrap_t  w0, w1, w2;
  logic [PW-1:0]    p0;
  logic [PW-1:0]    a_d, a_s;
  logic [MW-1:0]    md, ms;
  logic [MW-1:0]    b_d, b_s;
  logic [XW-1:0]    dd, ds;
  flam_pkg::addr_t  out_next;

  // Stage handshake, as in the coordinate pipeline.
  assign adv[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_adv
    assign adv[s] = ~v[s] | adv[s+1];
  end

  assign v_in     = {v[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (adv[s]) begin
          v[s] <= v_in[s];
        end
      end
    end
  end

  // Image times z size.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      w0 <= in_data;
      p0 <= PW'({{(PW + 1 - flam_pkg::IMAGE_W){1'b0}}, in_data.item.image_index} *
                {{(PW + 1 - SW){1'b0}}, geo.nz});
    end
  end

  // Add z and scale by the y size.
  always_comb begin
    a_d = p0 + PW'(w0.item.coord_z);
    a_s = p0 + PW'(w0.sz);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      w1 <= w0;
      md <= MW'({{(MW + 1 - PW){1'b0}}, a_d} * {{(MW + 1 - SW){1'b0}}, geo.ny});
      ms <= MW'({{(MW + 1 - PW){1'b0}}, a_s} * {{(MW + 1 - SW){1'b0}}, geo.ny});
    end
  end

  // Add y and scale by the row width of each layout.
  always_comb begin
    b_d = md + MW'(w1.item.coord_y);
    b_s = ms + MW'(w1.sy);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      w2 <= w1;
      dd <= {{(XW - MW){1'b0}}, b_d} * {{(XW - SW){1'b0}}, geo.new_row};
      ds <= {{(XW - MW){1'b0}}, b_s} * {{(XW - SW){1'b0}}, geo.old_row};
    end
  end

  // Add x into the output register.
  always_comb begin
    out_next.dest_index   = dd + XW'(w2.item.coord_x);
    out_next.source_index = ds + XW'(w2.sx);
    out_next.conjugate    = w2.conj;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      out_data <= out_next;
    end
  end

  assign out_valid = v[NS-1];

endmodule

[src/flam_checker.sv]
// Port-level checks of the Fourier layout address map, bound to the top level.
`include "fourier_layout_address_map_unit_macros.svh"

module flam_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              coord_valid,
  input logic                              coord_ready,
  input flam_pkg::coord_t                  coord,
  input logic                              addr_valid,
  input logic                              addr_ready,
  input flam_pkg::addr_t                   addr,
  input logic                              cfg_write,
  input logic [flam_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input logic [flam_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [flam_pkg::LAYOUT_W-1:0] old_layout;
  logic [flam_pkg::LAYOUT_W-1:0] new_layout;
  logic                          old_herm;
  logic                          new_herm;
  logic                          coord_seen;

  // Shadow copies of the layout registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      old_layout <= flam_pkg::LAY_STANDARD;
      new_layout <= flam_pkg::LAY_STANDARD;
    end else if (cfg_write && cfg_index == flam_pkg::REG_OLD_LAYOUT) begin
      old_layout <= cfg_data[flam_pkg::LAYOUT_W-1:0];
    end else if (cfg_write && cfg_index == flam_pkg::REG_NEW_LAYOUT) begin
      new_layout <= cfg_data[flam_pkg::LAYOUT_W-1:0];
    end
  end

  assign old_herm   = (old_layout == flam_pkg::LAY_HERM) || (old_layout == flam_pkg::LAY_CENTHERM);
  assign new_herm   = (new_layout == flam_pkg::LAY_HERM) || (new_layout == flam_pkg::LAY_CENTHERM);
  assign coord_seen = coord_valid && (coord.image_index == coord.image_index);

  // Reset empties the pipeline.
  `FLAM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !addr_valid, "output valid after reset")

  // A stalled result beat holds.
  `FLAM_ASSERT(a_out_hold, clk, rst, addr_valid && !addr_ready |=> addr_valid && $stable(addr), "stalled beat changed")

  // With no result waiting every stage can move, so input is taken.
  `FLAM_ASSERT(a_empty_ready, clk, rst, !addr_valid |-> coord_ready, "input refused with empty output")

  // Conjugation only happens when a hermitian source is expanded to a full layout.
  `FLAM_ASSERT(a_conj_expand, clk, rst, addr_valid && addr.conjugate |-> old_herm && !new_herm, "conjugate without expansion")

  // An offered coordinate leaves valid high until it is taken.
  `FLAM_ASSERT(a_in_hold, clk, rst, coord_seen && !coord_ready |=> coord_valid, "input valid dropped")

endmodule

bind fourier_layout_address_map_unit flam_checker u_flam_checker (
  .clk         (clk),
  .rst         (rst),
  .coord_valid (coord_valid),
  .coord_ready (coord_ready),
  .coord       (coord),
  .addr_valid  (addr_valid),
  .addr_ready  (addr_ready),
  .addr        (addr),
  .cfg_write   (cfg_write),
  .cfg_index   (cfg_index),
  .cfg_data    (cfg_data)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the Fourier layout address map: directed table, then random phases.
module tb_top;
  import flam_pkg::*;

  // Layout codes outside the known set; the block treats them as standard.
  localparam logic [LAYOUT_W-1:0] LAY_BAD_LO = 3'd5;
  localparam logic [LAYOUT_W-1:0] LAY_BAD_HI = 3'd7;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_PHASES   = 14;
  localparam int PHASE_BEATS  = 50;
  localparam int CALM_PHASE   = 5;
  localparam int IDLE_PCT     = 38;

  typedef struct packed {
    logic [SIZE_W-1:0]   size_x;
    logic [SIZE_W-1:0]   size_y;
    logic [SIZE_W-1:0]   size_z;
    logic [LAYOUT_W-1:0] old_layout;
    logic [LAYOUT_W-1:0] new_layout;
  } layout_cfg_t;

  typedef struct packed {
    layout_cfg_t cfg;
    coord_t      beat;
    logic        has_want;
    addr_t       want;
  } stim_row_t;

  localparam layout_cfg_t CFG_RESET = '{11'd1, 11'd1, 11'd1, LAY_STANDARD, LAY_STANDARD};
  localparam layout_cfg_t CFG_FULL  = '{MAX_DIM, MAX_DIM, MAX_DIM, LAY_STANDARD, LAY_STANDARD};
  localparam layout_cfg_t CFG_HX4   = '{11'd4, 11'd1, 11'd1, LAY_HERM, LAY_STANDARD};
  localparam layout_cfg_t CFG_EVEN  = '{11'd8, 11'd6, 11'd5, LAY_HERM, LAY_STANDARD};
  localparam coord_t      TOP_BEAT  = '{10'd1023, 10'd1023, 10'd1023, 8'd255};
  localparam coord_t      ZERO_BEAT = '{10'd0, 10'd0, 10'd0, 8'd0};

  // Extremes, mixed layout pairs, odd and even sizes, unknown codes and clipped sizes.
  localparam int NUM_DIRECTED = 22;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{CFG_RESET, ZERO_BEAT, 1'b1, '{38'd0, 38'd0, 1'b0}},
    '{CFG_RESET, TOP_BEAT,  1'b1, '{38'd3324, 38'd255, 1'b0}},
    '{CFG_FULL,  TOP_BEAT,  1'b1, '{38'h3F_FFFF_FFFF, 38'h3F_FFFF_FFFF, 1'b0}},
    '{CFG_FULL,  ZERO_BEAT, 1'b1, '{38'd0, 38'd0, 1'b0}},
    '{CFG_HX4, '{10'd3, 10'd0, 10'd0, 8'd0}, 1'b1, '{38'd3, 38'd1, 1'b1}},
    '{CFG_HX4, '{10'd2, 10'd0, 10'd0, 8'd0}, 1'b0, '0},
    '{CFG_EVEN, '{10'd7, 10'd5, 10'd4, 8'd3}, 1'b0, '0},
    '{CFG_EVEN, '{10'd5, 10'd0, 10'd0, 8'd1}, 1'b0, '0},
    '{'{11'd7, 11'd5, 11'd6, LAY_CENTHERM, LAY_CENTERED}, '{10'd6, 10'd4, 10'd5, 8'd1}, 1'b0, '0},
    '{'{11'd7, 11'd5, 11'd6, LAY_CENTHERM, LAY_STANDARD}, '{10'd4, 10'd0, 10'd0, 8'd2}, 1'b0, '0},
    '{'{11'd8, 11'd6, 11'd5, LAY_STANDARD, LAY_CENTERED}, ZERO_BEAT, 1'b0, '0},
    '{'{11'd8, 11'd6, 11'd5, LAY_CENTERED, LAY_HERM}, '{10'd4, 10'd5, 10'd4, 8'd7}, 1'b0, '0},
    '{'{11'd8, 11'd6, 11'd5, LAY_HERM, LAY_CENTHERM}, '{10'd3, 10'd2, 10'd1, 8'd0}, 1'b0, '0},
    '{'{11'd8, 11'd6, 11'd5, LAY_CENTHERM, LAY_HERM}, '{10'd4, 10'd3, 10'd2, 8'd9}, 1'b0, '0},
    '{'{11'd9, 11'd9, 11'd9, LAY_CENTERED, LAY_CENTERED}, '{10'd8, 10'd1, 10'd2, 8'd3}, 1'b0, '0},
    '{'{11'd9, 11'd9, 11'd9, LAY_NONE, LAY_CENTERED}, '{10'd3, 10'd3, 10'd3, 8'd0}, 1'b0, '0},
    '{'{11'd9, 11'd9, 11'd9, LAY_BAD_HI, LAY_HERM}, '{10'd4, 10'd8, 10'd8, 8'd4}, 1'b0, '0},
    '{'{11'd9, 11'd9, 11'd9, LAY_CENTHERM, LAY_BAD_LO}, '{10'd8, 10'd8, 10'd8, 8'd4}, 1'b0, '0},
    '{'{11'd9, 11'd9, 11'd9, LAY_HERM, LAY_NONE}, '{10'd6, 10'd0, 10'd7, 8'd5}, 1'b0, '0},
    '{'{11'd0, 11'd2047, 11'd0, LAY_HERM, LAY_CENTERED}, TOP_BEAT, 1'b0, '0},
    '{'{11'd2047, 11'd3, 11'd2047, LAY_CENTERED, LAY_STANDARD}, '{10'd1023, 10'd2, 10'd1023, 8'd255},
      1'b0, '0},
    '{CFG_EVEN, '{10'd1023, 10'd100, 10'd50, 8'd1}, 1'b0, '0}
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   coord_valid = 1'b0;
  logic   coord_ready;
  coord_t coord = '0;
  logic   addr_valid;
  logic   addr_ready = 1'b0;
  addr_t  addr;
  logic   cfg_write = 1'b0;
  logic   [CFG_ADDR_W-1:0] cfg_index = '0;
  logic   [CFG_DATA_W-1:0] cfg_data = '0;

  addr_t       pending_addrs [$];
  layout_cfg_t active_cfg = CFG_RESET;
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  bit          calm = 1'b0;

  fourier_layout_address_map_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_ready (coord_ready),
    .coord       (coord),
    .addr_valid  (addr_valid),
    .addr_ready  (addr_ready),
    .addr        (addr),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A size of zero acts as one, anything above the largest axis acts as the largest.
  function automatic int clip_dim(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_DIM) return int'(MAX_DIM);
    return int'(s);
  endfunction

  function automatic logic [LAYOUT_W-1:0] fold_layout(logic [LAYOUT_W-1:0] l);
    if (l < LAY_STANDARD || l > LAY_CENTHERM) return LAY_STANDARD;
    return l;
  endfunction

  function automatic bit half_spectrum(logic [LAYOUT_W-1:0] l);
    return l == LAY_HERM || l == LAY_CENTHERM;
  endfunction

  // The x origin of a centered half spectrum stays at zero.
  function automatic longint axis_origin(logic [LAYOUT_W-1:0] l, longint n, bit x_axis);
    if (l == LAY_CENTERED) return n / 2;
    if (l == LAY_CENTHERM && !x_axis) return n / 2;
    return 0;
  endfunction

  function automatic longint wrap_shift(longint c, longint o_src, longint o_dst, longint n);
    return ((c % n) + o_src - o_dst + n) % n;
  endfunction

  // Mirror of y or z for the Friedel mate; even and odd sizes fold differently.
  function automatic longint friedel_mirror(longint i, longint o_src, longint n);
    longint f;
    if (n % 2 == 0) f = (i != 0) ? n - i : 0;
    else f = 2 * o_src - i;
    if (f < 0) f += n;
    return f;
  endfunction

  // Expected output beat for one coordinate under a given configuration.
  function automatic addr_t map_address(layout_cfg_t g, coord_t c);
    longint nx, ny, nz, half, src_row, dst_row;
    longint ox_s, ox_d, oy_s, oy_d, oz_s, oz_d;
    longint xi, yi, zi, sx, sy, sz, dest, src;
    logic [LAYOUT_W-1:0] ol, nl;
    bit expand, conj;
    addr_t r;
    nx = longint'(clip_dim(g.size_x));
    ny = longint'(clip_dim(g.size_y));
    nz = longint'(clip_dim(g.size_z));
    ol = fold_layout(g.old_layout);
    nl = fold_layout(g.new_layout);
    half = nx / 2 + 1;
    src_row = half_spectrum(ol) ? half : nx;
    dst_row = half_spectrum(nl) ? half : nx;
    expand = half_spectrum(ol) && !half_spectrum(nl);
    ox_s = axis_origin(ol, nx, 1'b1);
    ox_d = axis_origin(nl, nx, 1'b1);
    oy_s = axis_origin(ol, ny, 1'b0);
    oy_d = axis_origin(nl, ny, 1'b0);
    oz_s = axis_origin(ol, nz, 1'b0);
    oz_d = axis_origin(nl, nz, 1'b0);
    if (ol == nl) begin
      ox_s = 0; ox_d = 0; oy_s = 0; oy_d = 0; oz_s = 0; oz_d = 0;
      expand = 1'b0;
    end
    xi = wrap_shift(longint'(c.coord_x), ox_s, ox_d, nx);
    yi = wrap_shift(longint'(c.coord_y), oy_s, oy_d, ny);
    zi = wrap_shift(longint'(c.coord_z), oz_s, oz_d, nz);
    conj = expand && xi >= half;
    if (conj) begin
      sx = (xi != 0) ? nx - xi : 0;
      sy = friedel_mirror(yi, oy_s, ny);
      sz = friedel_mirror(zi, oz_s, nz);
    end else begin
      sx = xi;
      sy = yi;
      sz = zi;
    end
    dest = ((longint'(c.image_index) * nz + c.coord_z) * ny + c.coord_y) * dst_row + c.coord_x;
    src = ((longint'(c.image_index) * nz + sz) * ny + sy) * src_row + sx;
    r.dest_index = INDEX_W'(dest);
    r.source_index = INDEX_W'(src);
    r.conjugate = conj;
    return r;
  endfunction

  // Mostly small sizes, with the largest axis and out-of-range values mixed in.
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      6, 7: return SIZE_W'($urandom_range(17, MAX_DIM));
      8: return MAX_DIM;
      9: return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
      default: return SIZE_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [LAYOUT_W-1:0] pick_layout();
    if ($urandom_range(0, 4) == 0) return LAYOUT_W'($urandom_range(LAY_NONE, LAY_BAD_HI));
    return LAYOUT_W'($urandom_range(LAY_STANDARD, LAY_CENTHERM));
  endfunction

  // Waits for the pipeline to drain, then writes all five registers.
  task automatic program_layout(layout_cfg_t g);
    coord_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SIZE_X;
    cfg_data <= g.size_x;
    @(negedge clk);
    cfg_index <= REG_SIZE_Y;
    cfg_data <= g.size_y;
    @(negedge clk);
    cfg_index <= REG_SIZE_Z;
    cfg_data <= g.size_z;
    @(negedge clk);
    cfg_index <= REG_OLD_LAYOUT;
    cfg_data <= CFG_DATA_W'(g.old_layout);
    @(negedge clk);
    cfg_index <= REG_NEW_LAYOUT;
    cfg_data <= CFG_DATA_W'(g.new_layout);
    @(negedge clk);
    cfg_write <= 1'b0;
    active_cfg = g;
  endtask

  // Offers one coordinate beat; the expectation is queued when the beat is taken.
  task automatic send_coord(coord_t c, logic has_want, addr_t want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      coord_valid <= 1'b0;
      @(negedge clk);
    end
    coord_valid <= 1'b1;
    coord <= c;
    @(posedge clk);
    while (!coord_ready) @(posedge clk);
    pending_addrs.push_back(has_want ? want : map_address(active_cfg, c));
    @(negedge clk);
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    addr_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each output beat with the oldest expectation.
  always @(posedge clk) begin
    addr_t want;
    if (!rst && addr_valid && addr_ready) begin
      if (pending_addrs.size() == 0) begin
        $error("unexpected address beat: dest_index %0d source_index %0d conjugate %0d",
               addr.dest_index, addr.source_index, addr.conjugate);
        mismatch_count++;
      end else begin
        want = pending_addrs.pop_front();
        if (addr.dest_index !== want.dest_index) begin
          $error("dest_index: expected %0d, actual %0d", want.dest_index, addr.dest_index);
          mismatch_count++;
        end
        if (addr.source_index !== want.source_index) begin
          $error("source_index: expected %0d, actual %0d", want.source_index,
                 addr.source_index);
          mismatch_count++;
        end
        if (addr.conjugate !== want.conjugate) begin
          $error("conjugate: expected %0d, actual %0d", want.conjugate, addr.conjugate);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if (rst || (coord_valid && coord_ready) || (addr_valid && addr_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    layout_cfg_t g;
    coord_t c;
    int nx, ny, nz, row;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg != active_cfg) program_layout(DIRECTED[i].cfg);
      send_coord(DIRECTED[i].beat, DIRECTED[i].has_want, DIRECTED[i].want);
    end

    // Random phases; every third one expands a half spectrum to a full layout.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      g.size_x = pick_size();
      g.size_y = pick_size();
      g.size_z = pick_size();
      if (phase % 3 == 0) begin
        g.old_layout = $urandom_range(0, 1) ? LAY_HERM : LAY_CENTHERM;
        g.new_layout = $urandom_range(0, 1) ? LAY_STANDARD : LAY_CENTERED;
      end else begin
        g.old_layout = pick_layout();
        g.new_layout = pick_layout();
      end
      program_layout(g);
      calm = (phase == CALM_PHASE);
      nx = clip_dim(g.size_x);
      ny = clip_dim(g.size_y);
      nz = clip_dim(g.size_z);
      row = half_spectrum(fold_layout(g.new_layout)) ? nx / 2 + 1 : nx;
      repeat (PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 85) begin
          c.coord_x = COORD_W'($urandom_range(0, row - 1));
          c.coord_y = COORD_W'($urandom_range(0, ny - 1));
          c.coord_z = COORD_W'($urandom_range(0, nz - 1));
        end else begin
          c.coord_x = COORD_W'($urandom);
          c.coord_y = COORD_W'($urandom);
          c.coord_z = COORD_W'($urandom);
        end
        c.image_index = IMAGE_W'($urandom);
        send_coord(c, 1'b0, '0);
      end
    end
    calm = 1'b0;

    coord_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
